// ===== rtl/core/psvd_pkg.sv =====
// Shared types, constants and the control store of the variable-timestep PID step unit.
package psvd_pkg;

    // Input and result words
    typedef struct packed {
        logic signed [15:0] error_sample;
        logic        [31:0] time_ms;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic signed [15:0] corrected_error;
        logic               dt_zero;
    } out_word_t;

    // Configuration register map
    typedef enum logic [1:0] {
        REG_KP_GAIN,
        REG_KD_GAIN,
        REG_KI_GAIN,
        REG_ERROR_OFFSET
    } reg_index_t;

    localparam logic signed [31:0] KP_GAIN_RESET      = 32'sd655360;
    localparam logic signed [31:0] KD_GAIN_RESET      = 32'sd6554;
    localparam logic signed [31:0] KI_GAIN_RESET      = 32'sd65536000;
    localparam logic signed [15:0] ERROR_OFFSET_RESET = 16'sd0;

    // Integral magnitude clamp, 2^41
    localparam int unsigned IT_W = 42;
    localparam logic [IT_W-1:0] IT_CLAMP = IT_W'(1) << 41;

    // Derivative divide: 40-bit dividend, one quotient bit per cycle
    localparam int unsigned QUO_W = 40;
    localparam int unsigned CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

    // Accumulator for the three signed terms
    localparam int unsigned ACC_W = 45;

    // Sequencer program counter and fixed program points
    localparam int unsigned PC_W = 4;
    localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
    localparam logic [PC_W-1:0] PC_PREP = 4'd1;
    localparam logic [PC_W-1:0] PC_DIV  = 4'd8;
    localparam logic [PC_W-1:0] PC_EMIT = 4'd11;

    // Control word fields
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_PREP,
        OP_ITERM,
        OP_DIV_STEP,
        OP_SUM_PD,
        OP_SUM_IT,
        OP_EMIT
    } alu_op_t;

    typedef enum logic [2:0] {
        MA_KP,
        MA_KD,
        MA_KI,
        MA_A_LO,
        MA_A_HI
    } mul_a_t;

    typedef enum logic [1:0] {
        MB_E,
        MB_DIFF,
        MB_S,
        MB_DT
    } mul_b_t;

    typedef enum logic [2:0] {
        MD_NONE,
        MD_P,
        MD_DNUM,
        MD_A,
        MD_LO,
        MD_HI
    } mul_dst_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_NO_INPUT,
        J_CNT_NZ,
        J_OUT_FULL
    } jump_t;

    typedef struct packed {
        alu_op_t         op;
        mul_a_t          mul_a;
        mul_b_t          mul_b;
        mul_dst_t        mul_dst;
        jump_t           jump;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // Control store: one word per step, jump taken when the condition holds
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t cw;
        cw = '{OP_NOP, MA_KP, MB_E, MD_NONE, J_ALWAYS, PC_IDLE};
        case (pc)
            4'd0:  cw = '{OP_LOAD,     MA_KP,   MB_E,    MD_NONE, J_NO_INPUT, PC_IDLE};
            4'd1:  cw = '{OP_PREP,     MA_KP,   MB_E,    MD_NONE, J_NEXT,     PC_IDLE};
            4'd2:  cw = '{OP_NOP,      MA_KP,   MB_E,    MD_P,    J_NEXT,     PC_IDLE};
            4'd3:  cw = '{OP_NOP,      MA_KD,   MB_DIFF, MD_DNUM, J_NEXT,     PC_IDLE};
            4'd4:  cw = '{OP_NOP,      MA_KI,   MB_S,    MD_A,    J_NEXT,     PC_IDLE};
            4'd5:  cw = '{OP_NOP,      MA_A_LO, MB_DT,   MD_LO,   J_NEXT,     PC_IDLE};
            4'd6:  cw = '{OP_NOP,      MA_A_HI, MB_DT,   MD_HI,   J_NEXT,     PC_IDLE};
            4'd7:  cw = '{OP_ITERM,    MA_KP,   MB_E,    MD_NONE, J_NEXT,     PC_IDLE};
            4'd8:  cw = '{OP_DIV_STEP, MA_KP,   MB_E,    MD_NONE, J_CNT_NZ,   PC_DIV};
            4'd9:  cw = '{OP_SUM_PD,   MA_KP,   MB_E,    MD_NONE, J_NEXT,     PC_IDLE};
            4'd10: cw = '{OP_SUM_IT,   MA_KP,   MB_E,    MD_NONE, J_NEXT,     PC_IDLE};
            4'd11: cw = '{OP_EMIT,     MA_KP,   MB_E,    MD_NONE, J_OUT_FULL, PC_EMIT};
            4'd12: cw = '{OP_NOP,      MA_KP,   MB_E,    MD_NONE, J_ALWAYS,   PC_IDLE};
            default: cw = '{OP_NOP, MA_KP, MB_E, MD_NONE, J_ALWAYS, PC_IDLE};
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/core/pid_step_variable_dt_unit.sv =====
// Variable-timestep PID step unit: microcoded sequencer, shared multiplier, serial divider.
//
// Each input word carries a Q8.8 error sample and a wrapping millisecond timestamp. The unit
// subtracts error_offset (saturating), takes dt as the timestamp difference mod 2^32, and
// returns drive = Kp*e + Kd*(e - previous e)/dt + Ki*(sum + e)*dt in Q16.16, each term
// truncated toward zero and the total saturated to 32 bits, plus the corrected error and a
// dt_zero flag (derivative term dropped). One word is worked on at a time: one 32x32
// multiplier is used over five steps and the derivative quotient comes from a restoring
// divider that yields one quotient bit per cycle, 40 bits in all. A new word is taken once
// the sequencer is back at its first step; a finished result waits in the output register
// without holding back the next word, and the sequencer waits at its emit step only while
// the previous result is still unread.
// Configuration writes take effect at once and belong between words.
module pid_step_variable_dt_unit
    import psvd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data
);

    // Sequencer
    logic [PC_W-1:0]  pc_reg, pc_next;
    ctrl_word_t       cw;
    logic             jump_taken;
    logic             accept;
    logic             out_full;

    // Configuration registers
    logic signed [31:0] kp_gain_reg, kp_gain_next;
    logic signed [31:0] kd_gain_reg, kd_gain_next;
    logic signed [31:0] ki_gain_reg, ki_gain_next;
    logic signed [15:0] error_offset_reg, error_offset_next;

    // Controller state
    logic signed [15:0] prev_error_reg, prev_error_next;
    logic signed [31:0] error_sum_reg, error_sum_next;
    logic        [31:0] prev_time_reg, prev_time_next;

    // Per-word working registers
    logic signed [15:0] e_reg, e_next;
    logic        [31:0] time_reg, time_next;
    logic        [31:0] dt_reg, dt_next;
    logic               dt_zero_reg, dt_zero_next;
    logic        [15:0] diff_mag_reg, diff_mag_next;
    logic               diff_neg_reg, diff_neg_next;
    logic        [31:0] s_mag_reg, s_mag_next;
    logic               s_neg_reg, s_neg_next;
    logic        [47:0] p_prod_reg, p_prod_next;
    logic        [47:0] dnum_reg, dnum_next;
    logic        [63:0] a_reg, a_next;
    logic        [63:0] lo_reg, lo_next;
    logic        [63:0] hi_reg, hi_next;
    logic [IT_W-1:0]    it_mag_reg, it_mag_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic        [31:0] rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    out_word_t          m_data_reg, m_data_next;

    // Datapath intermediates
    logic        [31:0] kp_mag, kd_mag, ki_mag;
    logic        [15:0] e_mag;
    logic        [31:0] mul_opa, mul_opb;
    logic        [63:0] mul_prod;
    logic signed [16:0] corr17;
    logic signed [15:0] corr_sat;
    logic signed [16:0] diff17, diff17_neg;
    logic signed [32:0] sum33, sum33_neg;
    logic signed [31:0] sum_sat;
    logic        [63:0] mid;
    logic        [48:0] it_frac;
    logic        [32:0] rem_sh;
    logic               div_ge;
    logic        [32:0] rem_sub;
    logic signed [ACC_W-1:0] p_term, d_term, it_term;
    logic signed [31:0] drive_sat;

    // Sign and magnitude to a signed accumulator operand
    function automatic logic signed [ACC_W-1:0] apply_sign(input logic [IT_W-1:0] m,
                                                          input logic neg);
        logic signed [ACC_W-1:0] v;
        v = signed'({{(ACC_W-IT_W){1'b0}}, m});
        return neg ? -v : v;
    endfunction

    // Control word and handshakes
    assign cw       = ucode_rom(pc_reg);
    assign s_ready  = (cw.op == OP_LOAD);
    assign accept   = s_valid && s_ready;
    assign out_full = m_valid_reg && !m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Next step
    always_comb begin
        case (cw.jump)
            J_NEXT:     jump_taken = 1'b0;
            J_ALWAYS:   jump_taken = 1'b1;
            J_NO_INPUT: jump_taken = !s_valid;
            J_CNT_NZ:   jump_taken = (cnt_reg != '0);
            J_OUT_FULL: jump_taken = out_full;
            default:    jump_taken = 1'b0;
        endcase
        pc_next = jump_taken ? cw.target : pc_reg + 1'b1;
    end

    // Magnitudes of gains and error
    assign kp_mag = kp_gain_reg[31] ? unsigned'(-kp_gain_reg) : unsigned'(kp_gain_reg);
    assign kd_mag = kd_gain_reg[31] ? unsigned'(-kd_gain_reg) : unsigned'(kd_gain_reg);
    assign ki_mag = ki_gain_reg[31] ? unsigned'(-ki_gain_reg) : unsigned'(ki_gain_reg);
    assign e_mag  = e_reg[15] ? unsigned'(-e_reg) : unsigned'(e_reg);

    // Shared 32x32 multiplier
    always_comb begin
        case (cw.mul_a)
            MA_KP:   mul_opa = kp_mag;
            MA_KD:   mul_opa = kd_mag;
            MA_KI:   mul_opa = ki_mag;
            MA_A_LO: mul_opa = a_reg[31:0];
            MA_A_HI: mul_opa = a_reg[63:32];
            default: mul_opa = '0;
        endcase
        case (cw.mul_b)
            MB_E:    mul_opb = {16'b0, e_mag};
            MB_DIFF: mul_opb = {16'b0, diff_mag_reg};
            MB_S:    mul_opb = s_mag_reg;
            MB_DT:   mul_opb = dt_reg;
            default: mul_opb = '0;
        endcase
    end
    assign mul_prod = {32'b0, mul_opa} * {32'b0, mul_opb};

    // Offset correction, saturated to 16 bits
    assign corr17 = {s_data.error_sample[15], s_data.error_sample}
                  - {error_offset_reg[15], error_offset_reg};
    assign corr_sat = (corr17[16] != corr17[15]) ? (corr17[16] ? 16'sh8000 : 16'sh7fff)
                                                 : corr17[15:0];

    // Error difference and running sum
    assign diff17     = {e_reg[15], e_reg} - {prev_error_reg[15], prev_error_reg};
    assign diff17_neg = -diff17;
    assign sum33      = {{17{e_reg[15]}}, e_reg} + {error_sum_reg[31], error_sum_reg};
    assign sum33_neg  = -sum33;
    assign sum_sat    = (sum33[32] != sum33[31])
                      ? (sum33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum33[31:0];

    // Integral magnitude from the split product, clamped
    assign mid     = hi_reg + {32'b0, lo_reg[63:32]};
    assign it_frac = {mid[16:0], lo_reg[31:0]};

    // Restoring divide step
    assign rem_sh  = {rem_reg, quo_reg[QUO_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, dt_reg});
    assign rem_sub = rem_sh - {1'b0, dt_reg};

    // Signed terms
    assign p_term  = apply_sign({2'b0, p_prod_reg[47:8]}, kp_gain_reg[31] ^ e_reg[15]);
    assign d_term  = dt_zero_reg ? '0
                   : apply_sign({2'b0, quo_reg}, kd_gain_reg[31] ^ diff_neg_reg);
    assign it_term = apply_sign(it_mag_reg, ki_gain_reg[31] ^ s_neg_reg);

    // Drive saturation
    assign drive_sat = (acc_reg[ACC_W-1:31] != {(ACC_W-31){acc_reg[31]}})
                     ? (acc_reg[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                     : acc_reg[31:0];

    // Configuration writes
    always_comb begin
        kp_gain_next      = kp_gain_reg;
        kd_gain_next      = kd_gain_reg;
        ki_gain_next      = ki_gain_reg;
        error_offset_next = error_offset_reg;
        if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_KP_GAIN:      kp_gain_next      = cfg_wdata;
                REG_KD_GAIN:      kd_gain_next      = cfg_wdata;
                REG_KI_GAIN:      ki_gain_next      = cfg_wdata;
                REG_ERROR_OFFSET: error_offset_next = cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Datapath next values, driven by the control word
    always_comb begin
        prev_error_next = prev_error_reg;
        error_sum_next  = error_sum_reg;
        prev_time_next  = prev_time_reg;
        e_next          = e_reg;
        time_next       = time_reg;
        dt_next         = dt_reg;
        dt_zero_next    = dt_zero_reg;
        diff_mag_next   = diff_mag_reg;
        diff_neg_next   = diff_neg_reg;
        s_mag_next      = s_mag_reg;
        s_neg_next      = s_neg_reg;
        p_prod_next     = p_prod_reg;
        dnum_next       = dnum_reg;
        a_next          = a_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        it_mag_next     = it_mag_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg;

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // multiplier destination
        case (cw.mul_dst)
            MD_P:    p_prod_next = mul_prod[47:0];
            MD_DNUM: dnum_next   = mul_prod[47:0];
            MD_A:    a_next      = mul_prod;
            MD_LO:   lo_next     = mul_prod;
            MD_HI:   hi_next     = mul_prod;
            default: ;
        endcase

        case (cw.op)
            OP_LOAD: begin
                if (accept) begin
                    e_next       = corr_sat;
                    time_next    = s_data.time_ms;
                    dt_next      = s_data.time_ms - prev_time_reg;
                    dt_zero_next = (s_data.time_ms == prev_time_reg);
                end
            end
            OP_PREP: begin
                diff_neg_next   = diff17[16];
                diff_mag_next   = diff17[16] ? diff17_neg[15:0] : diff17[15:0];
                s_neg_next      = sum33[32];
                s_mag_next      = sum33[32] ? sum33_neg[31:0] : sum33[31:0];
                prev_error_next = e_reg;
                error_sum_next  = sum_sat;
                prev_time_next  = time_reg;
            end
            OP_ITERM: begin
                it_mag_next = (|mid[63:17]) ? IT_CLAMP : {1'b0, it_frac[48:8]};
                quo_next    = dnum_reg[47:8];
                rem_next    = '0;
                cnt_next    = DIV_LAST;
            end
            OP_DIV_STEP: begin
                rem_next = div_ge ? rem_sub[31:0] : rem_sh[31:0];
                quo_next = {quo_reg[QUO_W-2:0], div_ge};
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            OP_SUM_PD: begin
                acc_next = p_term + d_term;
            end
            OP_SUM_IT: begin
                acc_next = acc_reg + it_term;
            end
            OP_EMIT: begin
                if (!out_full) begin
                    m_data_next.drive           = drive_sat;
                    m_data_next.corrected_error = e_reg;
                    m_data_next.dt_zero         = dt_zero_reg;
                    m_valid_next                = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg           <= PC_IDLE;
            cnt_reg          <= '0;
            m_valid_reg      <= 1'b0;
            kp_gain_reg      <= KP_GAIN_RESET;
            kd_gain_reg      <= KD_GAIN_RESET;
            ki_gain_reg      <= KI_GAIN_RESET;
            error_offset_reg <= ERROR_OFFSET_RESET;
            prev_error_reg   <= '0;
            error_sum_reg    <= '0;
            prev_time_reg    <= '0;
        end else begin
            pc_reg           <= pc_next;
            cnt_reg          <= cnt_next;
            m_valid_reg      <= m_valid_next;
            kp_gain_reg      <= kp_gain_next;
            kd_gain_reg      <= kd_gain_next;
            ki_gain_reg      <= ki_gain_next;
            error_offset_reg <= error_offset_next;
            prev_error_reg   <= prev_error_next;
            error_sum_reg    <= error_sum_next;
            prev_time_reg    <= prev_time_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        e_reg        <= e_next;
        time_reg     <= time_next;
        dt_reg       <= dt_next;
        dt_zero_reg  <= dt_zero_next;
        diff_mag_reg <= diff_mag_next;
        diff_neg_reg <= diff_neg_next;
        s_mag_reg    <= s_mag_next;
        s_neg_reg    <= s_neg_next;
        p_prod_reg   <= p_prod_next;
        dnum_reg     <= dnum_next;
        a_reg        <= a_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        it_mag_reg   <= it_mag_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        acc_reg      <= acc_next;
        m_data_reg   <= m_data_next;
    end

    // An accepted word always moves on to the prepare step
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (pc_reg == PC_PREP))
        else $error("accepted word did not advance to prepare step");

    // A result appears only from the emit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(pc_reg) == PC_EMIT))
        else $error("result raised outside emit step");

    // Divider count is idle outside the divide loop
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg != PC_DIV) |-> (cnt_reg == '0))
        else $error("divide counter busy outside divide step");

endmodule
